FILE: hw/rtl/pwa_pkg.sv
`default_nettype none
package pwa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_READ  = 2'd2,
    CMD_BEGIN = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  pixel_index;
    logic [15:0] sample_temp;
    logic [15:0] ambient_temp;
  } in_word_t;

  typedef struct packed {
    logic [15:0] mean_temp;
    logic [7:0]  sigma_code;
    logic [15:0] frame_count;
    logic [15:0] ambient_mean;
    logic        index_ok;
  } out_word_t;

  localparam int unsigned MEAN_W   = 32;
  localparam int unsigned DEV_W    = 48;
  localparam int unsigned DIVD_W   = 54;
  localparam int unsigned DIVS_W   = 17;
  localparam logic [15:0] FRAMES_MAX = 16'hFFFF;
  localparam logic [15:0] STEP_RESET = 16'd205;

endpackage
`default_nettype wire

FILE: hw/rtl/pwa_ram.sv
`default_nettype none
module pwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 768
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pwa_div.sv
`default_nettype none
module pwa_div
  import pwa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic      [DIVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W:0]   rem_sh;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem, quotient[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DIVD_W);
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        rem      <= fits ? DIVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pixel_welford_accumulator.sv
// pixel_welford_accumulator: per-pixel running mean and deviation sum
//
// in channel (in_valid/in_ready/in_data) carries one command word: add a
// pixel sample, close a frame with its ambient temperature, read a pixel,
// or begin a new interval. out channel (out_valid/out_ready/out_data)
// carries one word per read command and nothing for the others.
// cfg_write/cfg_data set the sigma step; write it only while idle.
//
// add sample: memory read, a 54-step serial division that forms the
// mean correction, multiply and write back. read pixel: up to two
// serial divisions (deviation over frames, ambient mean) and an 8-bit
// search, each bit through square, multiply and compare steps. frame
// done: counted in idle. begin interval and reset: a clearing sweep over
// all PIXEL_COUNT entries of both memories during which in_ready is low.
// one command is worked at a time. the result sits in an output register;
// a new command is taken while it waits, and a following read stalls at
// its last step until out_ready has drained the register.
`default_nettype none
module pixel_welford_accumulator
  import pwa_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = 768
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_write,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_DIV, S_ADD_MUL, S_ADD_WR,
    S_RD_RD, S_RD_LIM, S_RD_SQ, S_RD_MUL, S_RD_CMP, S_RD_AMB,
    S_RD_AMB_WAIT, S_RD_OUT
  } state_t;

  state_t       state;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] addr;
  logic [AW-1:0] rd_addr;
  logic          ok;
  logic [15:0]   sigma_step;
  logic [15:0]   interval_frames;
  logic [31:0]   ambient_sum;
  logic [15:0]   sample;

  logic [31:0]   m;
  logic [DEV_W-1:0] m2;
  logic          neg;
  logic [31:0]   ad;
  logic [31:0]   nm;
  logic [31:0]   ae;
  logic [63:0]   prod;
  logic [DIVD_W-1:0] limit;
  logic [31:0]   s2;
  logic [7:0]    q;
  logic [2:0]    bitn;
  logic [17:0]   osq;
  logic [49:0]   a;
  logic [15:0]   mean_out;
  logic [7:0]    sig;

  logic [31:0]   mean_rdata;
  logic [DEV_W-1:0] dev_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mean_wdata;
  logic [DEV_W-1:0] dev_wdata;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_q;

  logic          accept;
  logic [31:0]   x;
  logic [16:0]   n;
  logic          neg_c;
  logic [31:0]   ad_c;
  logic [31:0]   nm_c;
  logic [31:0]   ae_c;
  logic [40:0]   inc;
  logic [DEV_W:0] sum;
  logic [7:0]    t;
  logic [8:0]    odd;
  logic [15:0]   s;
  logic [16:0]   mean_rnd;
  logic          out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // read the entry at the accepting edge so it is ready in the cycle after
  assign rd_addr = (state == S_IDLE) ? in_data.pixel_index[AW-1:0] : addr;

  assign x   = {sample, 16'h0000};
  assign n   = {1'b0, interval_frames} + 17'd1;
  assign neg_c = x < mean_rdata;
  assign ad_c  = neg_c ? (mean_rdata - x) : (x - mean_rdata);
  assign nm_c  = neg ? (m - div_q[31:0]) : (m + div_q[31:0]);
  assign ae_c  = neg ? (nm_c - x) : (x - nm_c);
  assign inc   = 41'((65'(prod) + 65'(24'h800000)) >> 24);
  assign sum   = {1'b0, m2} + {8'h00, inc};
  assign t     = q | (8'd1 << bitn);
  assign odd   = {t, 1'b0} - 9'd1;
  assign s     = (sigma_step == 16'd0) ? 16'd1 : sigma_step;
  assign mean_rnd = {1'b0, mean_rdata[31:16]} + {16'h0000, mean_rdata[15]};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = {1'b0, interval_frames};
    case (state)
      S_ADD_RD: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'({1'b0, ad_c} + {17'h00000, n[16:1]});
        div_divisor  = n;
      end
      S_RD_RD: begin
        div_start    = ok && (interval_frames > 16'd1);
        div_dividend = {dev_rdata, 6'b000000};
      end
      S_RD_AMB: begin
        div_start    = (interval_frames != 16'd0);
        div_dividend = DIVD_W'({1'b0, ambient_sum} + {18'h00000, interval_frames[15:1]});
      end
      default: begin
      end
    endcase
  end

  assign mem_we     = (state == S_CLEAR) || (state == S_ADD_WR);
  assign mem_waddr  = (state == S_CLEAR) ? clr_cnt : addr;
  assign mean_wdata = (state == S_CLEAR) ? 32'h0 : nm;
  assign dev_wdata  = (state == S_CLEAR) ? '0 :
                      (sum[DEV_W] ? {DEV_W{1'b1}} : sum[DEV_W-1:0]);

  pwa_ram #(.WIDTH(MEAN_W), .DEPTH(PIXEL_COUNT)) u_mean_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mean_wdata),
    .raddr (rd_addr),
    .rdata (mean_rdata)
  );

  pwa_ram #(.WIDTH(DEV_W), .DEPTH(PIXEL_COUNT)) u_dev_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (dev_wdata),
    .raddr (rd_addr),
    .rdata (dev_rdata)
  );

  pwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_cnt         <= '0;
      sigma_step      <= STEP_RESET;
      interval_frames <= '0;
      ambient_sum     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        sigma_step <= cfg_data;
      end
      if (state == S_RD_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(PIXEL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr   <= in_data.pixel_index[AW-1:0];
            ok     <= {22'h0, in_data.pixel_index} < 32'(PIXEL_COUNT);
            sample <= in_data.sample_temp;
            case (cmd_t'(in_data.command))
              CMD_ADD: begin
                if ({22'h0, in_data.pixel_index} < 32'(PIXEL_COUNT)) begin
                  state <= S_ADD_RD;
                end
              end
              CMD_FRAME: begin
                if (interval_frames < FRAMES_MAX) begin
                  interval_frames <= interval_frames + 16'd1;
                  ambient_sum     <= ambient_sum + {16'h0000, in_data.ambient_temp};
                end
              end
              CMD_READ: begin
                state <= S_RD_RD;
              end
              CMD_BEGIN: begin
                interval_frames <= '0;
                ambient_sum     <= '0;
                clr_cnt         <= '0;
                state           <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_RD: begin
          m     <= mean_rdata;
          m2    <= dev_rdata;
          neg   <= neg_c;
          ad    <= ad_c;
          state <= S_ADD_DIV;
        end
        S_ADD_DIV: begin
          if (div_done) begin
            nm    <= nm_c;
            ae    <= ae_c;
            state <= S_ADD_MUL;
          end
        end
        S_ADD_MUL: begin
          prod  <= 64'(ad) * 64'(ae);
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          state <= S_IDLE;
        end
        S_RD_RD: begin
          q    <= '0;
          bitn <= 3'd7;
          sig  <= '0;
          if (!ok) begin
            mean_out <= '0;
            state    <= S_RD_AMB;
          end else begin
            mean_out <= mean_rnd[16] ? 16'hFFFF : mean_rnd[15:0];
            state    <= (interval_frames > 16'd1) ? S_RD_LIM : S_RD_AMB;
          end
        end
        S_RD_LIM: begin
          if (div_done) begin
            limit <= div_q;
            s2    <= 32'(s) * 32'(s);
            state <= S_RD_SQ;
          end
        end
        S_RD_SQ: begin
          osq   <= 18'(odd) * 18'(odd);
          state <= S_RD_MUL;
        end
        S_RD_MUL: begin
          a     <= 50'(osq) * 50'(s2);
          state <= S_RD_CMP;
        end
        S_RD_CMP: begin
          if ({4'h0, a} <= limit) begin
            q <= t;
          end
          bitn <= bitn - 3'd1;
          if (bitn == 3'd0) begin
            sig   <= ({4'h0, a} <= limit) ? t : q;
            state <= S_RD_AMB;
          end else begin
            state <= S_RD_SQ;
          end
        end
        S_RD_AMB: begin
          if (interval_frames == 16'd0) begin
            limit <= '0;
            state <= S_RD_OUT;
          end else begin
            state <= S_RD_AMB_WAIT;
          end
        end
        S_RD_AMB_WAIT: begin
          if (div_done) begin
            limit <= div_q;
            state <= S_RD_OUT;
          end
        end
        S_RD_OUT: begin
          if (out_free) begin
            out_data.mean_temp     <= mean_out;
            out_data.sigma_code    <= sig;
            out_data.frame_count   <= interval_frames;
            out_data.ambient_mean  <= (limit > DIVD_W'(16'hFFFF)) ? 16'hFFFF : limit[15:0];
            out_data.index_ok      <= ok;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (div_divisor != '0))
    else $error("divide started with zero divisor");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_busy)
    else $error("divider busy while taking a word");

  a_frames_hold: assert property (@(posedge clk) disable iff (rst)
    (!accept && state != S_CLEAR) |=> $stable(interval_frames))
    else $error("frame count moved without a word");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RD_OUT))
    else $error("result word without a read");

endmodule
`default_nettype wire
